// ===== rtl/pcmrd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcmrd_pkg
// Shared types and constants of the pcm24 ping-pong frame reader: command
// codes, frame geometry and the status and result records.
// ----------------------------------------------------------------------------
package pcmrd_pkg;

  // bytes in one stereo frame: two 24-bit little-endian samples
  localparam int FRAME_BYTES = 6;

  // floor(v / 6) == (v * DIV6_RECIP) >> DIV6_SHIFT for every 16-bit v
  localparam logic [16:0] DIV6_RECIP = 17'd43691;
  localparam int          DIV6_SHIFT = 18;

  typedef enum logic [2:0] {
    CMD_WRITE  = 3'd0,
    CMD_COMMIT = 3'd1,
    CMD_FAIL   = 3'd2,
    CMD_FRAME  = 3'd3,
    CMD_START  = 3'd4,
    CMD_STOP   = 3'd5
  } pcmrd_cmd_t;

  typedef struct packed {
    logic [31:0] underrun_total;
    logic        active_index;
    logic        b_needs_refill;
    logic        a_needs_refill;
    logic        b_full;
    logic        a_full;
  } pcmrd_status_t;

  typedef struct packed {
    logic signed [23:0] left_sample;
    logic signed [23:0] right_sample;
    logic               frame_valid;
    pcmrd_status_t      status;
  } pcmrd_result_t;

endpackage
`default_nettype wire

// ===== rtl/pcmrd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcmrd_ram
// Byte-wide sample store holding both buffers, one write port and one read
// port with a registered read.
// ----------------------------------------------------------------------------
module pcmrd_ram #(
  parameter int  DEPTH  = 65536,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== rtl/pcmrd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcmrd_ctrl
// Buffer bookkeeping: full and refill flags, lengths, read positions, active
// buffer, run flag and underrun count. Decides every command in the cycle of
// its transfer and requests a frame read from the store.
// ----------------------------------------------------------------------------
module pcmrd_ctrl
  import pcmrd_pkg::*;
#(
  parameter int  BUFFER_BYTES = 32768,
  localparam int ADDR_W       = $clog2(2 * BUFFER_BYTES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_fire,
  input  pcmrd_cmd_t        command,
  input  logic              buffer_sel,
  input  logic [15:0]       fill_count,
  output pcmrd_status_t     status_nxt,
  output logic              rd_go,
  output logic [ADDR_W-1:0] rd_base
);

  localparam int PAYLOAD_BYTES = (BUFFER_BYTES / FRAME_BYTES) * FRAME_BYTES;
  localparam int LEN_W         = $clog2(PAYLOAD_BYTES + 1);
  localparam logic [ADDR_W-1:0] B_BASE = ADDR_W'(BUFFER_BYTES);
  localparam logic [LEN_W:0]    STEP   = (LEN_W + 1)'(FRAME_BYTES);

  logic [1:0]       full_r, full_nxt;
  logic [1:0]       refill_r, refill_nxt;
  logic [LEN_W-1:0] len_r [2];
  logic [LEN_W-1:0] len_nxt [2];
  logic [LEN_W-1:0] pos_r [2];
  logic [LEN_W-1:0] pos_nxt [2];
  logic             active_r, active_nxt;
  logic             running_r, running_nxt;
  logic [31:0]      underrun_r, underrun_nxt;

  logic [15:0]      sat_cnt;
  logic [32:0]      q_prod;
  logic [14:0]      q_frames;
  logic [17:0]      rounded;
  logic [LEN_W-1:0] commit_len;

  logic             cur_buf;
  logic             read_ok;
  logic [LEN_W:0]   adv_pos;
  logic [LEN_W-1:0] rd_pos;

  // commit length: saturate to payload, round down to whole frames
  assign sat_cnt    = (32'(fill_count) > PAYLOAD_BYTES) ? 16'(PAYLOAD_BYTES) : fill_count;
  assign q_prod     = 33'(sat_cnt) * 33'(DIV6_RECIP);
  assign q_frames   = q_prod[DIV6_SHIFT +: 15];
  assign rounded    = {1'b0, q_frames, 2'b00} + {2'b00, q_frames, 1'b0};
  assign commit_len = LEN_W'(rounded);

  // command decode and next state
  always_comb begin
    full_nxt     = full_r;
    refill_nxt   = refill_r;
    len_nxt      = len_r;
    pos_nxt      = pos_r;
    active_nxt   = active_r;
    running_nxt  = running_r;
    underrun_nxt = underrun_r;
    cur_buf      = active_r;
    read_ok      = 1'b0;
    adv_pos      = '0;
    rd_pos       = '0;
    if (cmd_fire) begin
      unique case (command)
        CMD_COMMIT: begin
          len_nxt[buffer_sel]    = commit_len;
          pos_nxt[buffer_sel]    = '0;
          full_nxt[buffer_sel]   = (commit_len != '0);
          refill_nxt[buffer_sel] = 1'b0;
        end
        CMD_FAIL: begin
          len_nxt[buffer_sel]    = '0;
          pos_nxt[buffer_sel]    = '0;
          full_nxt[buffer_sel]   = 1'b0;
          refill_nxt[buffer_sel] = 1'b1;
        end
        CMD_FRAME: begin
          if (running_r) begin
            read_ok = 1'b1;
            // exhausted buffer: mark empty, then swap or underrun
            if (!full_r[cur_buf] ||
                ({1'b0, pos_r[cur_buf]} + STEP > {1'b0, len_r[cur_buf]})) begin
              full_nxt[cur_buf]   = 1'b0;
              refill_nxt[cur_buf] = 1'b1;
              pos_nxt[cur_buf]    = '0;
              if (full_r[!cur_buf]) begin
                active_nxt = !cur_buf;
                cur_buf    = !cur_buf;
              end else begin
                underrun_nxt = underrun_r + 32'd1;
                read_ok      = 1'b0;
              end
            end
            if (read_ok) begin
              rd_pos  = pos_nxt[cur_buf];
              adv_pos = {1'b0, pos_nxt[cur_buf]} + STEP;
              // last frame taken: mark empty at once
              if (adv_pos >= {1'b0, len_r[cur_buf]}) begin
                full_nxt[cur_buf]   = 1'b0;
                refill_nxt[cur_buf] = 1'b1;
                pos_nxt[cur_buf]    = '0;
              end else begin
                pos_nxt[cur_buf] = adv_pos[LEN_W-1:0];
              end
            end
          end
        end
        CMD_START: begin
          running_nxt = 1'b1;
          active_nxt  = 1'b0;
        end
        CMD_STOP: begin
          running_nxt = 1'b0;
          active_nxt  = 1'b0;
          full_nxt    = '0;
          refill_nxt  = '0;
          len_nxt[0]  = '0;
          len_nxt[1]  = '0;
          pos_nxt[0]  = '0;
          pos_nxt[1]  = '0;
        end
        default: ;
      endcase
    end
  end

  // frame read request into the byte store
  assign rd_go   = read_ok;
  assign rd_base = (cur_buf ? B_BASE : '0) + ADDR_W'(rd_pos);

  // status after the command
  assign status_nxt.underrun_total = underrun_nxt;
  assign status_nxt.active_index   = active_nxt;
  assign status_nxt.b_needs_refill = refill_nxt[1];
  assign status_nxt.a_needs_refill = refill_nxt[0];
  assign status_nxt.b_full         = full_nxt[1];
  assign status_nxt.a_full         = full_nxt[0];

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r     <= '0;
      refill_r   <= '0;
      len_r[0]   <= '0;
      len_r[1]   <= '0;
      pos_r[0]   <= '0;
      pos_r[1]   <= '0;
      active_r   <= 1'b0;
      running_r  <= 1'b0;
      underrun_r <= '0;
    end else begin
      full_r     <= full_nxt;
      refill_r   <= refill_nxt;
      len_r[0]   <= len_nxt[0];
      len_r[1]   <= len_nxt[1];
      pos_r[0]   <= pos_nxt[0];
      pos_r[1]   <= pos_nxt[1];
      active_r   <= active_nxt;
      running_r  <= running_nxt;
      underrun_r <= underrun_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pcmrd_fetch.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcmrd_fetch
// Frame fetch sequencer: issues six byte reads from the store, one per cycle,
// and assembles the two little-endian samples into a result.
// ----------------------------------------------------------------------------
module pcmrd_fetch
  import pcmrd_pkg::*;
#(
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ADDR_W-1:0] base,
  input  pcmrd_status_t     status_in,
  output logic              busy,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [7:0]        rd_data,
  output logic              done,
  output pcmrd_result_t     result
);

  localparam int CNT_W   = $clog2(FRAME_BYTES + 1);
  localparam int FRAME_W = 8 * FRAME_BYTES;

  logic                busy_r;
  logic                pend_r;
  logic [CNT_W-1:0]    issue_r;
  logic [CNT_W-1:0]    recv_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [FRAME_W-1:0]  shift_r;
  pcmrd_status_t       status_r;
  logic [FRAME_W-1:0]  frame;

  assign busy    = busy_r;
  assign rd_en   = busy_r && (issue_r != CNT_W'(FRAME_BYTES));
  assign rd_addr = addr_r;
  assign done    = pend_r && (recv_r == CNT_W'(FRAME_BYTES - 1));

  // sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      pend_r  <= 1'b0;
      issue_r <= '0;
      recv_r  <= '0;
    end else begin
      pend_r <= rd_en;
      if (start) begin
        busy_r  <= 1'b1;
        issue_r <= '0;
        recv_r  <= '0;
      end else begin
        if (done) begin
          busy_r <= 1'b0;
        end
        if (rd_en) begin
          issue_r <= issue_r + CNT_W'(1);
        end
        if (pend_r) begin
          recv_r <= recv_r + CNT_W'(1);
        end
      end
    end
  end

  // read address, returned bytes and held status
  always_ff @(posedge clk) begin
    if (start) begin
      addr_r   <= base;
      status_r <= status_in;
    end else if (rd_en) begin
      addr_r <= addr_r + ADDR_W'(1);
    end
    if (pend_r) begin
      shift_r <= {rd_data, shift_r[FRAME_W-1:8]};
    end
  end

  // last byte joins straight from the store
  assign frame               = {rd_data, shift_r[FRAME_W-1:8]};
  assign result.left_sample  = frame[23:0];
  assign result.right_sample = frame[47:24];
  assign result.frame_valid  = 1'b1;
  assign result.status       = status_r;

endmodule
`default_nettype wire

// ===== rtl/pcmrd_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcmrd_outq
// Two-entry result queue between the core and the output channel, so new
// commands are taken while a finished result waits.
// ----------------------------------------------------------------------------
module pcmrd_outq
  import pcmrd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pcmrd_result_t push_data,
  output logic          full,
  output logic          out_valid,
  input  logic          out_ready,
  output pcmrd_result_t out_data
);

  pcmrd_result_t entry_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    count_r;
  logic          pop;

  assign out_valid = (count_r != 2'd0);
  assign full      = (count_r == 2'd2);
  assign pop       = out_valid && out_ready;
  assign out_data  = entry_r[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pcm24_ping_pong_frame_reader_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcm24_ping_pong_frame_reader_core
// Ping-pong pair of byte buffers read as 24-bit stereo frames.
// ----------------------------------------------------------------------------
// Usage: every command arrives as one transfer on the in_ channel and gives
// exactly one result transfer on the out_ channel, in order. Commands write
// a byte, commit or fail a buffer fill, read a frame, start or stop.
// Write, commit, fail, start, stop, unused codes and frame requests that end
// in silence are decided in the cycle of their transfer; the result is
// offered in the cycle after; a new command is taken in the next cycle
// unless the result queue is full. A frame request that reads data issues
// six single-byte reads of the byte-wide sample store, one per cycle, pushes
// its result with the last returned byte and takes no new command meanwhile.
// Both buffers share one store of 2 * BUFFER_BYTES bytes; its contents are
// undefined after reset and are not cleared, so commands are taken in the
// first cycle after reset. Reset clears all flags, lengths, read positions,
// the active buffer, the run flag and the underrun count.
// Results go through a two-entry queue: a stalled receiver leaves up to two
// results waiting, then in_tready drops until one is taken.
// ----------------------------------------------------------------------------
module pcm24_ping_pong_frame_reader_core
  import pcmrd_pkg::*;
#(
  parameter int BUFFER_BYTES = 32768
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // byte_offset[14:0], data_byte[22:15], fill_count[38:23], zero [39]
  input  logic [39:0] in_tdata,
  // command[2:0], buffer_sel[3]
  input  logic [3:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // left_sample[23:0], right_sample[47:24], underrun_total[79:48],
  // a_full[80], b_full[81], a_needs_refill[82], b_needs_refill[83],
  // active_index[84], zero [87:85]
  output logic [87:0] out_tdata,
  // frame_valid[0]
  output logic [0:0]  out_tuser
);

  localparam int ADDR_W = $clog2(2 * BUFFER_BYTES);
  localparam logic [ADDR_W-1:0] B_BASE = ADDR_W'(BUFFER_BYTES);

  pcmrd_cmd_t        in_cmd;
  logic              in_sel;
  logic [14:0]       in_off;
  logic [7:0]        in_byte;
  logic [15:0]       in_fill;
  logic              in_fire;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;

  pcmrd_status_t     status_nxt;
  logic              rd_go;
  logic [ADDR_W-1:0] rd_base;

  logic              fetch_busy;
  logic              fetch_rd_en;
  logic [ADDR_W-1:0] fetch_rd_addr;
  logic [7:0]        ram_rd_data;
  logic              fetch_done;
  pcmrd_result_t     fetch_result;

  pcmrd_result_t     imm_result;
  pcmrd_result_t     push_data;
  logic              push;
  logic              q_full;
  pcmrd_result_t     q_data;

  // input field unpacking
  assign in_cmd  = pcmrd_cmd_t'(in_tuser[2:0]);
  assign in_sel  = in_tuser[3];
  assign in_off  = in_tdata[14:0];
  assign in_byte = in_tdata[22:15];
  assign in_fill = in_tdata[38:23];

  assign in_tready = !fetch_busy && !q_full;
  assign in_fire   = in_tvalid && in_tready;

  // byte writes land in the selected half of the store
  assign wr_en   = in_fire && (in_cmd == CMD_WRITE) && (32'(in_off) < BUFFER_BYTES);
  assign wr_addr = (in_sel ? B_BASE : '0) + ADDR_W'(in_off);

  pcmrd_ctrl #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_fire   (in_fire),
    .command    (in_cmd),
    .buffer_sel (in_sel),
    .fill_count (in_fill),
    .status_nxt (status_nxt),
    .rd_go      (rd_go),
    .rd_base    (rd_base)
  );

  pcmrd_ram #(
    .DEPTH (2 * BUFFER_BYTES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_byte),
    .rd_en   (fetch_rd_en),
    .rd_addr (fetch_rd_addr),
    .rd_data (ram_rd_data)
  );

  pcmrd_fetch #(
    .ADDR_W (ADDR_W)
  ) u_fetch (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rd_go),
    .base      (rd_base),
    .status_in (status_nxt),
    .busy      (fetch_busy),
    .rd_en     (fetch_rd_en),
    .rd_addr   (fetch_rd_addr),
    .rd_data   (ram_rd_data),
    .done      (fetch_done),
    .result    (fetch_result)
  );

  // results without sample data go out at once
  assign imm_result.left_sample  = '0;
  assign imm_result.right_sample = '0;
  assign imm_result.frame_valid  = 1'b0;
  assign imm_result.status       = status_nxt;

  assign push      = (in_fire && !rd_go) || fetch_done;
  assign push_data = fetch_done ? fetch_result : imm_result;

  pcmrd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (q_data)
  );

  // output packing
  assign out_tdata = {3'b000,
                      q_data.status.active_index,
                      q_data.status.b_needs_refill,
                      q_data.status.a_needs_refill,
                      q_data.status.b_full,
                      q_data.status.a_full,
                      q_data.status.underrun_total,
                      q_data.right_sample,
                      q_data.left_sample};
  assign out_tuser = q_data.frame_valid;

endmodule
`default_nettype wire
